### src/mtcr_pkg.sv
`timescale 1ns / 1ps

package mtcr_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	// Register word offsets (byte address divided by four).
	localparam logic [7:0] OFS_CONTROL = 8'd0;
	localparam logic [7:0] OFS_CONFIG  = 8'd64;
	localparam logic [7:0] OFS_TIME_LO = 8'd65;
	localparam logic [7:0] OFS_TIME_HI = 8'd66;
	localparam logic [7:0] OFS_CMP_LO  = 8'd67;
	localparam logic [7:0] OFS_CMP_HI  = 8'd68;
	localparam logic [7:0] OFS_ENABLE  = 8'd69;
	localparam logic [7:0] OFS_PENDING = 8'd70;
	localparam logic [7:0] OFS_TEST    = 8'd71;

	localparam logic [31:0] CONFIG_RESET  = 32'h0001_0000;
	localparam logic [63:0] COMPARE_RESET = {64{1'b1}};

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  word_offset;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        bad_offset;
		logic        intr_out;
		logic        machine_timer_out;
	} rsp_t;

endpackage

### src/mtcr_req_if.sv
`timescale 1ns / 1ps

interface mtcr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  word_offset;
	logic [31:0] write_data;

	modport source (output valid, command, word_offset, write_data, input ready);
	modport sink (input valid, command, word_offset, write_data, output ready);
endinterface

### src/mtcr_rsp_if.sv
`timescale 1ns / 1ps

interface mtcr_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        bad_offset;
	logic        intr_out;
	logic        machine_timer_out;

	modport source (output valid, read_data, bad_offset, intr_out, machine_timer_out,
		input ready);
	modport sink (input valid, read_data, bad_offset, intr_out, machine_timer_out,
		output ready);
endinterface

### src/mtcr_core.sv
`timescale 1ns / 1ps

module mtcr_core
	import mtcr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  req_t item,
	output rsp_t result
);

	logic [31:0] ctrl_q, cfg_q, ie_q, is_q, test_q;
	logic [63:0] time_q, cmp_q, target_q;
	logic        armed_q, intr_q, mtip_q;

	logic [31:0] ctrl_d, cfg_d, ie_d, is_d, test_d;
	logic [63:0] time_d, cmp_d, target_d;
	logic        armed_d, intr_d, mtip_d;

	logic [63:0] time_inc;
	logic [63:0] cmp_new;
	logic [31:0] rdata;
	logic        mapped;
	logic        bad;
	logic        fire;

	always_comb begin
		unique case (item.word_offset)
			OFS_CONTROL, OFS_CONFIG, OFS_TIME_LO, OFS_TIME_HI, OFS_CMP_LO,
			OFS_CMP_HI, OFS_ENABLE, OFS_PENDING, OFS_TEST: mapped = 1'b1;
			default: mapped = 1'b0;
		endcase
	end

	assign time_inc = time_q + 64'd1;

	always_comb begin
		ctrl_d   = ctrl_q;
		cfg_d    = cfg_q;
		ie_d     = ie_q;
		is_d     = is_q;
		test_d   = test_q;
		time_d   = time_q;
		cmp_d    = cmp_q;
		target_d = target_q;
		armed_d  = armed_q;
		intr_d   = intr_q;
		mtip_d   = mtip_q;
		rdata    = '0;
		bad      = 1'b0;
		fire     = 1'b0;
		cmp_new  = cmp_q;

		case (item.command)
			CMD_TICK: begin
				time_d = time_inc;
				fire   = armed_q && (time_inc >= target_q);
			end
			CMD_READ: begin
				if (!mapped) begin
					bad = 1'b1;
				end else begin
					case (item.word_offset)
						OFS_CONTROL: rdata = ctrl_q;
						OFS_CONFIG:  rdata = cfg_q;
						OFS_TIME_LO: rdata = time_q[31:0];
						OFS_TIME_HI: rdata = time_q[63:32];
						OFS_CMP_LO:  rdata = cmp_q[31:0];
						OFS_CMP_HI:  rdata = cmp_q[63:32];
						OFS_ENABLE:  rdata = ie_q;
						OFS_PENDING: rdata = is_q;
						OFS_TEST:    rdata = test_q;
						default:     rdata = '0;
					endcase
				end
			end
			CMD_WRITE: begin
				if (!mapped) begin
					bad = 1'b1;
				end else begin
					case (item.word_offset)
						OFS_CONTROL: ctrl_d = item.write_data;
						OFS_CONFIG:  cfg_d  = item.write_data;
						OFS_ENABLE:  ie_d   = item.write_data;
						OFS_PENDING: is_d   = is_q & ~item.write_data;
						OFS_TEST: begin
							test_d = item.write_data;
							if (ie_q[0] && item.write_data[0]) begin
								is_d[0] = 1'b1;
								intr_d  = 1'b1;
							end
						end
						OFS_CMP_LO, OFS_CMP_HI: begin
							if (item.word_offset == OFS_CMP_LO) begin
								cmp_new = {cmp_q[63:32], item.write_data};
							end else begin
								cmp_new = {item.write_data, cmp_q[31:0]};
							end
							cmp_d = cmp_new;
							// The compare is only evaluated while the timer is active.
							if (ctrl_q[0]) begin
								if (cmp_new <= time_q) begin
									fire = 1'b1;
								end else begin
									mtip_d   = 1'b0;
									intr_d   = 1'b0;
									target_d = cmp_new;
									armed_d  = 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase

		// Firing raises the core line, flags pending when enabled and disarms.
		if (fire) begin
			mtip_d  = 1'b1;
			armed_d = 1'b0;
			if (ie_q[0]) begin
				is_d[0] = 1'b1;
				intr_d  = 1'b1;
			end
		end
	end

	assign result.read_data         = rdata;
	assign result.bad_offset        = bad;
	assign result.intr_out          = intr_d;
	assign result.machine_timer_out = mtip_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q   <= '0;
			cfg_q    <= CONFIG_RESET;
			ie_q     <= '0;
			is_q     <= '0;
			test_q   <= '0;
			time_q   <= '0;
			cmp_q    <= COMPARE_RESET;
			target_q <= '0;
			armed_q  <= 1'b0;
			intr_q   <= 1'b0;
			mtip_q   <= 1'b0;
		end else if (go) begin
			ctrl_q   <= ctrl_d;
			cfg_q    <= cfg_d;
			ie_q     <= ie_d;
			is_q     <= is_d;
			test_q   <= test_d;
			time_q   <= time_d;
			cmp_q    <= cmp_d;
			target_q <= target_d;
			armed_q  <= armed_d;
			intr_q   <= intr_d;
			mtip_q   <= mtip_d;
		end
	end

endmodule

### src/machine_timer_compare_regs_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Carries
// req      sink       command, word_offset, write_data
// rsp      source     read_data, bad_offset, intr_out, machine_timer_out
//
// Every beat on req yields exactly one beat on rsp, through the input register and
// then the result register. One beat per cycle is sustained unless rsp is stalled;
// the rate is set by the combinational register update and 64-bit increment and
// compare in mtcr_core. Reset brings the core registers and valid flags to their
// defined values at once; no clearing pass. A stall on rsp holds the result register
// and the input register in turn, and req.ready falls only when both are full.

module machine_timer_compare_regs_unit
	import mtcr_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	mtcr_req_if.sink    req,
	mtcr_rsp_if.source  rsp
);

	// Input register: the accepted beat waits here until the core can process it.
	req_t req_s1;
	logic req_valid_s1;

	// Result register: holds the finished result until the sink takes it.
	rsp_t rsp_q;
	logic rsp_valid_q;

	rsp_t result;
	logic advance;

	// The core commits state for the item in the input register whenever the result
	// register is free or being emptied in this cycle.
	assign advance   = req_valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !req_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req.ready) begin
			req_valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.command     <= req.command;
			req_s1.word_offset <= req.word_offset;
			req_s1.write_data  <= req.write_data;
		end
	end

	mtcr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.item   (req_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.read_data         = rsp_q.read_data;
	assign rsp.bad_offset        = rsp_q.bad_offset;
	assign rsp.intr_out          = rsp_q.intr_out;
	assign rsp.machine_timer_out = rsp_q.machine_timer_out;

endmodule
